// File: sv/mm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

	localparam int DIM_W   = 5;
	localparam int IDX_W   = 4;
	localparam int ELEM_IN = 16;
	localparam int ACC_W   = 40;
	localparam int MAX_DIM_DEF    = 16;
	localparam int ELEM_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} reg_idx_t;

	// zero reads as one, anything above the cap reads as the cap
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
		input logic [DIM_W-1:0] cap);
		logic [DIM_W-1:0] res;
		res = value;
		if (value == '0) begin
			res = DIM_W'(1);
		end else if (value > cap) begin
			res = cap;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: sv/matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+-------------------------
// request   | cmd, row_index, col_index, element_value          | start high, busy low
// result    | product_value, out_col, last_in_row, error_flag   | result_valid, one cycle
// config    | cfg_index, cfg_data                               | cfg_write, no wait
//
// loads never raise busy. a compute request runs one shared
// multiply-accumulate over both stores: cols_b * inner_dim products, each passing
// through read, multiply and accumulate, so at most 256 products per row.
// a compute for a row outside the sizes answers with an error result in the next cycle.
// reset clears control state and sets all sizes to their maximum; the stores
// hold nothing defined until loaded. results cannot be stalled.
module matrix_multiply #(
	parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output      logic                                 busy,
	input  wire logic [1:0]                           cmd,
	input  wire logic [mm_pkg::IDX_W-1:0]             row_index,
	input  wire logic [mm_pkg::IDX_W-1:0]             col_index,
	input  wire logic signed [mm_pkg::ELEM_IN-1:0]    element_value,
	input  wire logic                                 cfg_write,
	input  wire logic [1:0]                           cfg_index,
	input  wire logic [mm_pkg::DIM_W-1:0]             cfg_data,
	output      logic                                 result_valid,
	output      logic signed [mm_pkg::ACC_W-1:0]      product_value,
	output      logic [mm_pkg::IDX_W-1:0]             out_col,
	output      logic                                 last_in_row,
	output      logic                                 error_flag
);

	localparam int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH   = 1 << (2 * AW);
	localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
	localparam int PW      = 2 * ELEM_WIDTH;
	localparam int SW      = ((PW > mm_pkg::ACC_W) ? PW : mm_pkg::ACC_W) + 2;
	localparam logic [mm_pkg::DIM_W-1:0] CAP = mm_pkg::DIM_W'(DIM_CAP);
	localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (mm_pkg::ACC_W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd1 <<< (mm_pkg::ACC_W - 1));

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef struct packed {
		logic                     valid;
		logic                     first_k;
		logic                     last_k;
		logic                     last_c;
		logic [mm_pkg::IDX_W-1:0] col;
	} tag_t;

	state_t state_q;
	logic [mm_pkg::DIM_W-1:0] rows_a_q, inner_q, cols_q;
	logic [mm_pkg::IDX_W-1:0] row_q, k_q, c_q;
	logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
	logic [ELEM_WIDTH-1:0] rd_a_s1, rd_b_s1;
	logic signed [PW-1:0]  prod_s2;
	tag_t tag_s0, tag_s1, tag_s2;
	logic accept, k_end, c_end;
	logic [2*AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic signed [SW-1:0] sum;
	logic row_ok, load_a_ok, load_b_ok;

	assign accept = start && !busy;
	assign busy   = (state_q == ST_RUN) || tag_s1.valid || tag_s2.valid;
	assign k_end  = ({1'b0, k_q} == inner_q - mm_pkg::DIM_W'(1));
	assign c_end  = ({1'b0, c_q} == cols_q - mm_pkg::DIM_W'(1));

	assign row_ok    = {1'b0, row_index} < rows_a_q;
	assign load_a_ok = row_ok && ({1'b0, col_index} < inner_q);
	assign load_b_ok = ({1'b0, row_index} < inner_q) && ({1'b0, col_index} < cols_q);
	assign wr_addr   = {AW'(row_index), AW'(col_index)};
	assign wr_data   = ELEM_WIDTH'(element_value);

	assign rd_addr_a = {AW'(row_q), AW'(k_q)};
	assign rd_addr_b = {AW'(k_q), AW'(c_q)};

	always_comb begin
		tag_s0.valid   = (state_q == ST_RUN);
		tag_s0.first_k = (k_q == '0);
		tag_s0.last_k  = k_end;
		tag_s0.last_c  = c_end;
		tag_s0.col     = c_q;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CAP;
			inner_q  <= CAP;
			cols_q   <= CAP;
		end else if (cfg_write) begin
			case (cfg_index)
				mm_pkg::REG_ROWS_A:    rows_a_q <= mm_pkg::clamp_dim(cfg_data, CAP);
				mm_pkg::REG_INNER_DIM: inner_q  <= mm_pkg::clamp_dim(cfg_data, CAP);
				mm_pkg::REG_COLS_B:    cols_q   <= mm_pkg::clamp_dim(cfg_data, CAP);
				default: ;
			endcase
		end
	end

	// stores: written by loads, read through a register addressed by the issue counters
	always_ff @(posedge clk) begin
		if (accept && cmd == mm_pkg::CMD_LOAD_A && load_a_ok) begin
			mem_a[wr_addr] <= wr_data;
		end
		rd_a_s1 <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == mm_pkg::CMD_LOAD_B && load_b_ok) begin
			mem_b[wr_addr] <= wr_data;
		end
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	// issue sequencer: k runs inside c
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			c_q     <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd == mm_pkg::CMD_COMPUTE && row_ok) begin
						state_q <= ST_RUN;
						row_q   <= row_index;
						k_q     <= '0;
						c_q     <= '0;
					end
				end
				ST_RUN: begin
					if (k_end) begin
						k_q <= '0;
						c_q <= c_q + mm_pkg::IDX_W'(1);
						if (c_end) begin
							state_q <= ST_IDLE;
						end
					end else begin
						k_q <= k_q + mm_pkg::IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(rd_a_s1) * $signed(rd_b_s1);
	end

	// accumulate with saturation after every add
	always_comb begin
		if (tag_s2.first_k) begin
			sum = SW'(prod_s2);
		end else begin
			sum = SW'(product_value) + SW'(prod_s2);
		end
		if (sum > SAT_MAX) begin
			sum = SAT_MAX;
		end else if (sum < SAT_MIN) begin
			sum = SAT_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (tag_s2.valid && tag_s2.last_k)
				|| (accept && cmd == mm_pkg::CMD_COMPUTE && !row_ok);
		end
	end

	// the running sum doubles as the result register; it holds for the strobe cycle
	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			product_value <= mm_pkg::ACC_W'(sum);
			out_col       <= tag_s2.col;
			last_in_row   <= tag_s2.last_c;
			error_flag    <= 1'b0;
		end else if (accept && cmd == mm_pkg::CMD_COMPUTE && !row_ok) begin
			product_value <= '0;
			out_col       <= '0;
			last_in_row   <= 1'b1;
			error_flag    <= 1'b1;
		end
	end

endmodule

`default_nettype wire
